[design/tca_pkg.sv]
// ----------------------------------------------------------------------------
// tca_pkg
// Types and constants shared by the tumor cell automaton update block.
// ----------------------------------------------------------------------------
package tca_pkg;

  localparam int unsigned HOURS_PER_DAY = 24;
  localparam logic [23:0] Q824_MAX      = 24'hFF_FFFF;
  localparam int unsigned DIV_STEPS     = 21;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_UPDATE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ACT_STAYED   = 2'd0,
    ACT_DIED     = 2'd1,
    ACT_MIGRATED = 2'd2,
    ACT_DIVIDED  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_SYM_PROB    = 2'd0,
    CFG_STEP_LENGTH = 2'd1,
    CFG_DAUGHTER_DIV = 2'd2,
    CFG_DAUGHTER_DEATH = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  row;
    logic [7:0]  col;
    logic        seed_cancer;
    logic [7:0]  seed_cycle_hours;
    logic [7:0]  seed_divisions;
    logic [9:0]  seed_migration;
    logic [15:0] seed_death_prob;
    logic [15:0] action_draw;
    logic [15:0] neighbor_draw;
    logic [15:0] symmetric_draw;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_row;
    logic [7:0] out_col;
    logic [1:0] action;
    logic       keep_active;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [15:0] death;
    logic [9:0]  migration;
    logic [7:0]  divisions;
    logic [7:0]  cycle;
    logic        cancer;
  } cell_t;

  typedef struct packed {
    logic [15:0] sym_prob;
    logic [15:0] step_length;
    logic [7:0]  daughter_div;
    logic [15:0] daughter_death;
  } cfg_t;

  typedef struct packed {
    cmd_t cmd;
    logic in_grid;
  } entry_t;

  typedef struct packed {
    logic signed [9:0] r;
    logic signed [9:0] c;
  } pos_t;

  // Counterclockwise neighbour order starting at the upper left.
  function automatic pos_t nb_pos(logic [7:0] row, logic [7:0] col, logic [2:0] k);
    logic signed [9:0] r;
    logic signed [9:0] c;
    pos_t p;
    r = signed'({2'b00, row});
    c = signed'({2'b00, col});
    case (k)
      3'd0: begin p.r = r - 10'sd1; p.c = c - 10'sd1; end
      3'd1: begin p.r = r;          p.c = c - 10'sd1; end
      3'd2: begin p.r = r + 10'sd1; p.c = c - 10'sd1; end
      3'd3: begin p.r = r + 10'sd1; p.c = c;          end
      3'd4: begin p.r = r + 10'sd1; p.c = c + 10'sd1; end
      3'd5: begin p.r = r;          p.c = c + 10'sd1; end
      3'd6: begin p.r = r - 10'sd1; p.c = c + 10'sd1; end
      default: begin p.r = r - 10'sd1; p.c = c;       end
    endcase
    return p;
  endfunction

endpackage

[design/tca_ram.sv]
// ----------------------------------------------------------------------------
// tca_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tca_ram #(
  parameter int unsigned WIDTH = 43,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/tca_front.sv]
// ----------------------------------------------------------------------------
// tca_front
// Accepts command beats, tags whether the site lies in the grid and queues
// them for the back end in a two entry queue.
// ----------------------------------------------------------------------------
module tca_front import tca_pkg::*; #(
  parameter int unsigned GRID_SIDE = 256
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  cmd_t   cmd_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  entry_t     slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  entry_t     ent;

  always_comb begin
    ent.cmd     = cmd_i;
    ent.in_grid = (32'(cmd_i.row) < 32'(GRID_SIDE)) && (32'(cmd_i.col) < 32'(GRID_SIDE));
  end

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= ent;
    end
  end

endmodule

[design/tca_back.sv]
// ----------------------------------------------------------------------------
// tca_back
// Carries out queued commands on the grid memory: clears the grid after
// reset, writes records, and runs the neighbour scan, weight arithmetic and
// action choice of an update.
// ----------------------------------------------------------------------------
module tca_back import tca_pkg::*; #(
  parameter int unsigned GRID_SIDE = 256
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    valid_i,
  input  entry_t  entry_i,
  output logic    pop_o,
  output logic    clearing_o,
  output logic    result_valid_o,
  output result_t result_o
);

  localparam int unsigned DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned AXW   = AW + 10;

  typedef enum logic [14:0] {
    S_CLEAR  = 15'b000_0000_0000_0001,
    S_IDLE   = 15'b000_0000_0000_0010,
    S_WRITE  = 15'b000_0000_0000_0100,
    S_READ   = 15'b000_0000_0000_1000,
    S_DRAIN  = 15'b000_0000_0001_0000,
    S_CHECK  = 15'b000_0000_0010_0000,
    S_DIV    = 15'b000_0000_0100_0000,
    S_MUL1   = 15'b000_0000_1000_0000,
    S_MUL2   = 15'b000_0001_0000_0000,
    S_SUM    = 15'b000_0010_0000_0000,
    S_MUL3   = 15'b000_0100_0000_0000,
    S_PICK   = 15'b000_1000_0000_0000,
    S_DECIDE = 15'b001_0000_0000_0000,
    S_WR2    = 15'b010_0000_0000_0000,
    S_OUT2   = 15'b100_0000_0000_0000
  } state_e;

  function automatic logic [AW-1:0] site_addr(logic signed [9:0] r, logic signed [9:0] c);
    logic [AXW-1:0] a;
    a = AXW'(unsigned'(r)) * AXW'(GRID_SIDE) + AXW'(unsigned'(c));
    return a[AW-1:0];
  endfunction

  function automatic logic pos_in_grid(pos_t p);
    return !p.r[9] && !p.c[9] && (32'(unsigned'(p.r)) < 32'(GRID_SIDE)) &&
           (32'(unsigned'(p.c)) < 32'(GRID_SIDE));
  endfunction

  state_e         state_q, state_d;
  entry_t         cur_q, cur_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [3:0]     idx_q, idx_d;
  logic           rd_v_q;
  logic [3:0]     rd_pos_q;
  cell_t          cell_q;
  logic [7:0]     free_q;
  logic [4:0]     cnt_q, cnt_d;
  logic [7:0]     dvs_q, dvs_d;
  logic [7:0]     rem_q, rem_d;
  logic [20:0]    quo_q, quo_d;
  logic [16:0]    a_q, a_d;
  logic [25:0]    b_q, b_d;
  logic [20:0]    pde_q, pde_d;
  logic [23:0]    mig_q, mig_d;
  logic [25:0]    total_q, total_d;
  logic [25:0]    p_q, p_d;
  logic [2:0]     pick_q, pick_d;
  logic [2:0]     sel_q, sel_d;
  logic           res_v_q, res_v_d;
  result_t        res_q, res_d;

  pos_t           center;
  pos_t           nb [8];
  logic [7:0]     nbv;
  pos_t           rd_p;
  pos_t           new_p;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  cell_t          mem_wdata;
  logic [42:0]    mem_rdata;
  cell_t          rd_cell;
  cell_t          child;
  cell_t          seed;
  logic [8:0]     rem_sh;
  logic [9:0]     diff;
  logic [42:0]    prod2;
  logic [26:0]    mig_raw;
  logic [41:0]    prod3;
  logic [3:0]     nfree;
  logic [19:0]    pprod;
  logic [2:0]     praw;
  logic [3:0]     seen;
  logic [24:0]    dm_sum;

  assign rd_cell = cell_t'(mem_rdata);

  always_comb begin
    center.r = signed'({2'b00, cur_q.cmd.row});
    center.c = signed'({2'b00, cur_q.cmd.col});
    for (int k = 0; k < 8; k++) begin
      nb[k]  = nb_pos(cur_q.cmd.row, cur_q.cmd.col, 3'(k));
      nbv[k] = pos_in_grid(nb[k]);
    end
    rd_p  = (idx_q == 4'd0) ? center : nb[3'(idx_q - 4'd1)];
    new_p = nb[sel_q];
  end

  always_comb begin
    seed.cancer    = cur_q.cmd.seed_cancer;
    seed.cycle     = cur_q.cmd.seed_cycle_hours;
    seed.divisions = cur_q.cmd.seed_divisions;
    seed.migration = cur_q.cmd.seed_migration;
    seed.death     = cur_q.cmd.seed_death_prob;
    child.cancer    = 1'b1;
    child.cycle     = cell_q.cycle;
    child.migration = cell_q.migration;
    if (cell_q.death == 16'd0) begin
      if (cur_q.cmd.symmetric_draw < cfg_i.sym_prob) begin
        child = cell_q;
      end else begin
        child.divisions = cfg_i.daughter_div;
        child.death     = cfg_i.daughter_death;
      end
    end else begin
      child.divisions = (cell_q.divisions != 8'd0) ? cell_q.divisions - 8'd1 : 8'd0;
      child.death     = cell_q.death;
    end
  end

  always_comb begin
    rem_sh  = {rem_q, quo_q[20]};
    diff    = {1'b0, rem_sh} - {2'b00, dvs_q};
    prod2   = 43'(a_q) * 43'(b_q);
    mig_raw = prod2[42:16];
    prod3   = 42'(cur_q.cmd.action_draw) * 42'(total_q);
    nfree   = 4'($countones(free_q));
    pprod   = 20'(cur_q.cmd.neighbor_draw) * 20'(nfree);
    praw    = pprod[18:16];
    dm_sum  = 25'(cell_q.death) + 25'(mig_q);
  end

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    clr_d    = clr_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    a_d      = a_q;
    b_d      = b_q;
    pde_d    = pde_q;
    mig_d    = mig_q;
    total_d  = total_q;
    p_d      = p_q;
    pick_d   = pick_q;
    sel_d    = sel_q;
    res_v_d  = 1'b0;
    res_d    = res_q;
    pop_o    = 1'b0;
    mem_we   = 1'b0;
    mem_waddr = site_addr(center.r, center.c);
    mem_wdata = '0;
    mem_raddr = site_addr(rd_p.r, rd_p.c);
    seen     = 4'd0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          cur_d = entry_i;
          idx_d = 4'd0;
          if (entry_i.cmd.kind == KIND_WRITE) begin
            if (entry_i.in_grid) begin
              state_d = S_WRITE;
            end
          end else if (!entry_i.in_grid) begin
            res_v_d = 1'b1;
            res_d   = '{entry_i.cmd.row, entry_i.cmd.col, ACT_STAYED, 1'b0, 1'b1};
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = seed;
        state_d   = S_IDLE;
      end
      S_READ: begin
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd8) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!cell_q.cancer) begin
          res_v_d = 1'b1;
          res_d   = '{cur_q.cmd.row, cur_q.cmd.col, ACT_STAYED, 1'b0, 1'b1};
          state_d = S_IDLE;
        end else if (free_q == 8'd0) begin
          res_v_d = 1'b1;
          res_d   = '{cur_q.cmd.row, cur_q.cmd.col, ACT_STAYED, 1'b1, 1'b1};
          state_d = S_IDLE;
        end else begin
          dvs_d   = (cell_q.cycle == 8'd0) ? 8'd1 : cell_q.cycle;
          rem_d   = 8'd0;
          quo_d   = 21'(cfg_i.step_length) * 21'(HOURS_PER_DAY);
          cnt_d   = 5'(DIV_STEPS - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!diff[9]) begin
          rem_d = diff[7:0];
        end else begin
          rem_d = rem_sh[7:0];
        end
        quo_d = {quo_q[19:0], !diff[9]};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        a_d     = (quo_q < 21'h10000) ? 17'h10000 - 17'(quo_q) : 17'd0;
        b_d     = 26'(cell_q.migration) * 26'(cfg_i.step_length);
        pde_d   = (cell_q.divisions == 8'd0) ? 21'd0 : quo_q;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        mig_d   = (mig_raw > 27'(Q824_MAX)) ? Q824_MAX : mig_raw[23:0];
        state_d = S_SUM;
      end
      S_SUM: begin
        total_d = 26'(cell_q.death) + 26'(mig_q) + 26'(pde_q);
        state_d = S_MUL3;
      end
      S_MUL3: begin
        p_d     = prod3[41:16];
        pick_d  = (4'(praw) >= nfree) ? 3'(nfree - 4'd1) : praw;
        state_d = S_PICK;
      end
      S_PICK: begin
        sel_d = 3'd0;
        for (int k = 0; k < 8; k++) begin
          if (free_q[k]) begin
            if (seen == {1'b0, pick_q}) begin
              sel_d = 3'(k);
            end
            seen = seen + 4'd1;
          end
        end
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        res_v_d = 1'b1;
        mem_we  = 1'b1;
        if (p_q < 26'(cell_q.death)) begin
          mem_wdata = '0;
          res_d     = '{cur_q.cmd.row, cur_q.cmd.col, ACT_DIED, 1'b0, 1'b1};
          state_d   = S_IDLE;
        end else if (p_q < 26'(dm_sum)) begin
          mem_waddr = site_addr(new_p.r, new_p.c);
          mem_wdata = cell_q;
          res_d     = '{new_p.r[7:0], new_p.c[7:0], ACT_MIGRATED, 1'b1, 1'b1};
          state_d   = S_WR2;
        end else begin
          mem_waddr = site_addr(new_p.r, new_p.c);
          mem_wdata = child;
          res_d     = '{new_p.r[7:0], new_p.c[7:0], ACT_DIVIDED, 1'b1, 1'b0};
          state_d   = S_OUT2;
        end
      end
      S_WR2: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        state_d   = S_IDLE;
      end
      S_OUT2: begin
        res_v_d = 1'b1;
        res_d   = '{cur_q.cmd.row, cur_q.cmd.col, ACT_DIVIDED, 1'b1, 1'b1};
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  tca_ram #(
    .WIDTH(43),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      idx_q   <= 4'd0;
      cnt_q   <= 5'd0;
      rd_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      rd_v_q  <= state_q == S_READ;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    dvs_q    <= dvs_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    a_q      <= a_d;
    b_q      <= b_d;
    pde_q    <= pde_d;
    mig_q    <= mig_d;
    total_q  <= total_d;
    p_q      <= p_d;
    pick_q   <= pick_d;
    sel_q    <= sel_d;
    res_q    <= res_d;
    rd_pos_q <= idx_q;
    if (rd_v_q) begin
      if (rd_pos_q == 4'd0) begin
        cell_q <= rd_cell;
      end else begin
        free_q[3'(rd_pos_q - 4'd1)] <= nbv[3'(rd_pos_q - 4'd1)] & ~rd_cell.cancer;
      end
    end
  end

  assign clearing_o     = state_q == S_CLEAR;
  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !res_v_q)
    else $error("result beat during grid clearing");

  a_first_beat_followed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && !res_q.last) |=> (res_v_q && res_q.last))
    else $error("first division beat not followed by final beat");

  a_died_not_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && res_q.action == ACT_DIED) |-> !res_q.keep_active)
    else $error("dead cell kept active");

  a_divided_two_beats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && res_q.action == ACT_DIVIDED && res_q.last) |->
      $past(res_v_q && !res_q.last))
    else $error("division final beat without first beat");

endmodule

[design/tumor_cell_automaton_update.sv]
// ----------------------------------------------------------------------------
// tumor_cell_automaton_update
// Grid of tumor cell records with write and update commands; an update scans
// the eight neighbours and lets the cell die, migrate or divide.
// ----------------------------------------------------------------------------
// After reset the block holds busy high while it clears the grid memory one
// site per cycle. Configuration writes are taken during that time. A write
// command takes the back end through its write state. An update reads the
// center and the eight neighbours one per cycle from the single read port of
// the grid memory. If the site is empty or has no free neighbour, the update
// ends there. Otherwise a 21 step shift-subtract divider computes the division
// weight and three registered multiplies follow. An update of a site outside
// the grid is answered from the idle state without a memory read. Result beats
// appear on result_valid_o for one cycle each and cannot be held off. A
// division gives two beats in consecutive cycles. A two entry command queue
// lets start be taken while the previous command is still in work.
module tumor_cell_automaton_update import tca_pkg::*; #(
  parameter int unsigned GRID_SIDE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  cmd_t        cmd_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        result_valid_o,
  output result_t     result_o
);

  cfg_t   cfg_q;
  logic   fe_full;
  logic   be_clearing;
  logic   q_valid;
  logic   q_pop;
  entry_t q_entry;

  assign busy = fe_full || be_clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sym_prob       <= 16'd6554;
      cfg_q.step_length    <= 16'd2731;
      cfg_q.daughter_div   <= 8'd10;
      cfg_q.daughter_death <= 16'd655;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SYM_PROB:       cfg_q.sym_prob       <= cfg_wdata_i;
        CFG_STEP_LENGTH:    cfg_q.step_length    <= cfg_wdata_i;
        CFG_DAUGHTER_DIV:   cfg_q.daughter_div   <= cfg_wdata_i[7:0];
        CFG_DAUGHTER_DEATH: cfg_q.daughter_death <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  tca_front #(
    .GRID_SIDE(GRID_SIDE)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (start && !busy),
    .cmd_i  (cmd_i),
    .full_o (fe_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .entry_o(q_entry)
  );

  tca_back #(
    .GRID_SIDE(GRID_SIDE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .valid_i       (q_valid),
    .entry_i       (q_entry),
    .pop_o         (q_pop),
    .clearing_o    (be_clearing),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule
